@@ rtl/snlmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlmf_pkg
// Types, constants and glyph tables for the number to LED matrix frame block.
// ----------------------------------------------------------------------------
package snlmf_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned RowW   = 8;
  localparam int unsigned RestW  = 10;  // magnitude modulo one thousand
  localparam int unsigned QuotW  = 7;   // rest divided by ten, 0..99
  localparam int unsigned DigitW = 4;

  localparam logic [ValueW-1:0] SatLimit = 16'd1999;
  localparam logic [10:0]       Thousand = 11'd1000;
  localparam logic [RowW-1:0]   MarkBit  = 8'h80;

  // x / 100 == (x * 5243) >> 19 and x / 10 == (x * 205) >> 11 for x below 1000
  localparam int unsigned HundMulW = 23;
  localparam logic [HundMulW-1:0] HundRecip = 23'd5243;
  localparam int unsigned HundShift = 19;
  localparam int unsigned TenMulW = 18;
  localparam logic [TenMulW-1:0] TenRecip = 18'd205;
  localparam int unsigned TenShift = 11;

  typedef logic [4:0][3:0] glyph_t;

  typedef struct packed {
    logic             neg;
    logic             thou;
    logic [RestW-1:0] rest;
  } sat_t;

  typedef struct packed {
    logic              neg;
    logic              thou;
    logic [RestW-1:0]  rest;
    logic [QuotW-1:0]  quot;
    logic [DigitW-1:0] hund;
  } quot_t;

  typedef struct packed {
    logic              neg;
    logic              thou;
    logic [DigitW-1:0] hund;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] ones;
  } digit_t;

  // 3x5 glyph, entry 0 is the top row
  function automatic glyph_t digit_glyph(input logic [DigitW-1:0] d);
    glyph_t g;
    case (d)
      4'd0:    g = {4'h7, 4'h5, 4'h5, 4'h5, 4'h7};
      4'd1:    g = {4'h4, 4'h4, 4'h4, 4'h4, 4'h4};
      4'd2:    g = {4'h7, 4'h1, 4'h7, 4'h4, 4'h7};
      4'd3:    g = {4'h7, 4'h4, 4'h7, 4'h4, 4'h7};
      4'd4:    g = {4'h4, 4'h4, 4'h7, 4'h5, 4'h5};
      4'd5:    g = {4'h7, 4'h4, 4'h7, 4'h1, 4'h7};
      4'd6:    g = {4'h7, 4'h5, 4'h7, 4'h1, 4'h7};
      4'd7:    g = {4'h4, 4'h4, 4'h4, 4'h4, 4'h7};
      4'd8:    g = {4'h7, 4'h5, 4'h7, 4'h5, 4'h7};
      4'd9:    g = {4'h7, 4'h4, 4'h7, 4'h5, 4'h7};
      default: g = '0;
    endcase
    return g;
  endfunction

  // bar graph rows, {row6, row7}
  function automatic logic [2*RowW-1:0] bar_rows(input logic [DigitW-1:0] d);
    logic [2*RowW-1:0] b;
    case (d)
      4'd0:    b = {8'h00, 8'h00};
      4'd1:    b = {8'h00, 8'h40};
      4'd2:    b = {8'h40, 8'h60};
      4'd3:    b = {8'h60, 8'h70};
      4'd4:    b = {8'h70, 8'h78};
      4'd5:    b = {8'h78, 8'h7c};
      4'd6:    b = {8'h7c, 8'h7e};
      4'd7:    b = {8'h7e, 8'h7f};
      4'd8:    b = {8'h7f, 8'hff};
      4'd9:    b = {8'hff, 8'hff};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/snlmf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlmf_in_if
// Request channel carrying one signed number.
// ----------------------------------------------------------------------------
interface snlmf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ rtl/snlmf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlmf_out_if
// Request channel carrying one 8x8 frame as eight row bytes.
// ----------------------------------------------------------------------------
interface snlmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] row0;
  logic [7:0] row1;
  logic [7:0] row2;
  logic [7:0] row3;
  logic [7:0] row4;
  logic [7:0] row5;
  logic [7:0] row6;
  logic [7:0] row7;

  modport source (output valid, output row0, output row1, output row2, output row3,
                  output row4, output row5, output row6, output row7, input ready);
  modport sink (input valid, input row0, input row1, input row2, input row3,
                input row4, input row5, input row6, input row7, output ready);
endinterface

@@ rtl/snlmf_sat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlmf_sat
// Stage 1: magnitude, saturation to 1999 and split off of the thousands.
// ----------------------------------------------------------------------------
module snlmf_sat
  import snlmf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output sat_t                     data_o
);

  logic              valid_q;
  logic              en;
  sat_t              data_d, data_q;
  logic [ValueW-1:0] mag;
  logic [10:0]       sat;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    // -32768 gives 0x8000, which is still the right unsigned magnitude
    mag = value_i[ValueW-1] ? (~value_i + 16'd1) : value_i;
    sat = (mag > SatLimit) ? SatLimit[10:0] : mag[10:0];
    data_d.neg  = value_i[ValueW-1];
    data_d.thou = (sat >= Thousand);
    data_d.rest = data_d.thou ? RestW'(sat - Thousand) : sat[RestW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/snlmf_digits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlmf_digits
// Stages 2 and 3: reciprocal multiplies, then hundreds, tens and ones digits.
// ----------------------------------------------------------------------------
module snlmf_digits
  import snlmf_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  sat_t   data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output digit_t data_o
);

  logic                valid2_q, valid3_q;
  logic                en2, en3;
  quot_t               quot_d, quot_q;
  digit_t              dig_d, dig_q;
  logic [HundMulW-1:0] hund_prod;
  logic [TenMulW-1:0]  ten_prod;
  logic [RestW-1:0]    tens_x10;
  logic [QuotW-1:0]    hund_x10;

  assign en3     = !valid3_q || ready_i;
  assign en2     = !valid2_q || en3;
  assign ready_o = en2;

  // stage 2: rest / 100 and rest / 10 by reciprocal
  always_comb begin
    hund_prod   = HundMulW'(data_i.rest) * HundRecip;
    ten_prod    = TenMulW'(data_i.rest) * TenRecip;
    quot_d.neg  = data_i.neg;
    quot_d.thou = data_i.thou;
    quot_d.rest = data_i.rest;
    quot_d.quot = ten_prod[TenShift +: QuotW];
    quot_d.hund = hund_prod[HundShift +: DigitW];
  end

  // stage 3: remainders give tens and ones
  always_comb begin
    tens_x10   = RestW'(quot_q.quot) * RestW'(10);
    hund_x10   = QuotW'(quot_q.hund) * QuotW'(10);
    dig_d.neg  = quot_q.neg;
    dig_d.thou = quot_q.thou;
    dig_d.hund = quot_q.hund;
    dig_d.tens = DigitW'(quot_q.quot - hund_x10);
    dig_d.ones = DigitW'(quot_q.rest - tens_x10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      if (en2) begin
        valid2_q <= valid_i;
      end
      if (en3) begin
        valid3_q <= valid2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && valid_i) begin
      quot_q <= quot_d;
    end
    if (en3 && valid2_q) begin
      dig_q <= dig_d;
    end
  end

  assign valid_o = valid3_q;
  assign data_o  = dig_q;

`ifndef ASSERT_OFF
  a_rest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> data_i.rest < RestW'(1000))
    else $error("rest out of range");
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid2_q |-> (quot_q.hund < DigitW'(10)) && (quot_q.quot < QuotW'(100)))
    else $error("quotient out of range");
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid3_q |-> (dig_q.hund < DigitW'(10)) && (dig_q.tens < DigitW'(10)) &&
                 (dig_q.ones < DigitW'(10)))
    else $error("digit out of range");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid3_q && !ready_i |=> valid3_q && $stable(dig_q))
    else $error("stage 3 lost a request");
`endif

endmodule

@@ rtl/snlmf_render.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlmf_render
// Stage 4: glyph and bar graph lookup into the output frame register.
// ----------------------------------------------------------------------------
module snlmf_render
  import snlmf_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  digit_t         data_i,
  snlmf_out_if.source    out_if
);

  logic                   valid_q;
  logic                   en;
  glyph_t                 hund_g, tens_g;
  logic [2*RowW-1:0]      bar;
  logic [7:0][RowW-1:0]   rows_d, rows_q;

  assign en      = !valid_q || out_if.ready;
  assign ready_o = en;

  always_comb begin
    hund_g = digit_glyph(data_i.hund);
    tens_g = digit_glyph(data_i.tens);
    bar    = bar_rows(data_i.ones);
    for (int i = 0; i < 5; i++) begin
      rows_d[i] = {tens_g[i], hund_g[i]};
    end
    rows_d[5] = data_i.thou ? MarkBit : '0;
    rows_d[6] = bar[2*RowW-1:RowW];
    rows_d[7] = bar[RowW-1:0];
    if (data_i.neg) begin
      rows_d[2] = rows_d[2] | MarkBit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      rows_q <= rows_d;
    end
  end

  assign out_if.valid = valid_q;
  assign out_if.row0  = rows_q[0];
  assign out_if.row1  = rows_q[1];
  assign out_if.row2  = rows_q[2];
  assign out_if.row3  = rows_q[3];
  assign out_if.row4  = rows_q[4];
  assign out_if.row5  = rows_q[5];
  assign out_if.row6  = rows_q[6];
  assign out_if.row7  = rows_q[7];

endmodule

@@ rtl/signed_number_to_led_matrix_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_number_to_led_matrix_frame
// Turns a signed 16-bit number into one 8x8 LED matrix frame of eight rows.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one signed number per request, out_if one frame (row0..row7)
//   per request, both with valid/ready. Every input request gives exactly one
//   frame, in order. The number saturates to +/-1999.
// Pipeline: four register stages (saturate, reciprocal multiplies, digit
//   remainders, glyph lookup into the output register) lie between the
//   accepting edge and out_if.valid.
// Throughput: one request per cycle while out_if.ready is high; the deepest
//   logic is the 10x13 bit reciprocal multiply of stage 2.
// Reset: rst_ni clears all stage valid bits; the pipeline comes up empty and
//   in_if.ready is high in the first cycle after reset.
// Stall: when out_if.ready is low the frame holds; earlier stages keep
//   filling empty slots, and in_if.ready drops once every stage holds a
//   request. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module signed_number_to_led_matrix_frame
  import snlmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  snlmf_in_if.sink    in_if,
  snlmf_out_if.source out_if
);

  logic   s1_valid, s1_ready;
  sat_t   s1_data;
  logic   s3_valid, s3_ready;
  digit_t s3_data;

  snlmf_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_if.valid),
    .ready_o (in_if.ready),
    .value_i (in_if.value),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  snlmf_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  snlmf_render u_render (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .out_if  (out_if)
  );

endmodule
